/* design/djs_pkg.sv */
// ----------------------------------------------------------------------------
// djs_pkg: shared types and constants of the deadline job scheduler
// Field widths, the stored job record, slot table control and sequencer states.
// ----------------------------------------------------------------------------
package djs_pkg;

    localparam int IDENT_W  = 8;
    localparam int DL_W     = 8;
    localparam int PROFIT_W = 16;
    localparam int SLOT_W   = 5;
    localparam int TOTAL_W  = 21;
    localparam int COUNT_W  = 6;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic [IDENT_W-1:0]  ident;
        logic [DL_W-1:0]     deadline;
        logic [PROFIT_W-1:0] profit;
    } t_job_rec;

    typedef struct packed {
        logic set;
        logic clear;
    } t_slot_ctl;

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_SCAN = 4'b0010,
        S_SLOT = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

endpackage

/* design/djs_job_store.sv */
// ----------------------------------------------------------------------------
// djs_job_store: job record memory
// One write port for loading, one registered read port for the profit scan.
// ----------------------------------------------------------------------------
module djs_job_store #(
    parameter int JOB_CAPACITY = 32,
    localparam int IW = $clog2(JOB_CAPACITY)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [IW-1:0]     i_wr_addr,
    input  djs_pkg::t_job_rec i_wr_rec,
    input  logic [IW-1:0]     i_rd_addr,
    output djs_pkg::t_job_rec o_rd_rec
);
    import djs_pkg::*;

    t_job_rec r_mem [JOB_CAPACITY];
    t_job_rec r_rd_rec;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_rec;
        end
        r_rd_rec <= r_mem[i_rd_addr];
    end

    assign o_rd_rec = r_rd_rec;

endmodule

/* design/djs_slot_table.sv */
// ----------------------------------------------------------------------------
// djs_slot_table: time slot occupancy and slot identifier memory
// Occupancy bits clear at once; identifiers sit in a memory with a registered
// read port for the emission walk.
// ----------------------------------------------------------------------------
module djs_slot_table #(
    parameter int JOB_CAPACITY = 32,
    localparam int IW = $clog2(JOB_CAPACITY)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  djs_pkg::t_slot_ctl           i_ctl,
    input  logic [IW-1:0]                i_wr_addr,
    input  logic [djs_pkg::IDENT_W-1:0]  i_wr_ident,
    output logic                         o_chk_taken,
    input  logic [IW-1:0]                i_rd_addr,
    output logic                         o_rd_taken,
    output logic [djs_pkg::IDENT_W-1:0]  o_rd_ident
);
    import djs_pkg::*;

    logic [JOB_CAPACITY-1:0] r_taken;
    logic [JOB_CAPACITY-1:0] n_taken;
    logic [IDENT_W-1:0]      r_ident [JOB_CAPACITY];
    logic                    r_rd_taken;
    logic [IDENT_W-1:0]      r_rd_ident;

    always_comb begin
        n_taken = r_taken;
        if (i_ctl.clear) begin
            n_taken = '0;
        end else if (i_ctl.set) begin
            n_taken[i_wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
        end else begin
            r_taken <= n_taken;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.set) begin
            r_ident[i_wr_addr] <= i_wr_ident;
        end
        r_rd_ident <= r_ident[i_rd_addr];
        r_rd_taken <= r_taken[i_rd_addr];
    end

    assign o_chk_taken = r_taken[i_wr_addr];
    assign o_rd_taken  = r_rd_taken;
    assign o_rd_ident  = r_rd_ident;

endmodule

/* design/deadline_job_scheduler.sv */
// ----------------------------------------------------------------------------
// deadline_job_scheduler: greedy job sequencing with deadlines
// Loads jobs one per transfer, schedules the batch by profit and emits the
// occupied slots in slot order.
// ----------------------------------------------------------------------------
// Input channel: a job transfers on a rising edge with start high and busy low.
//   busy stays low until the job marked last; jobs beyond JOB_CAPACITY are
//   dropped, and a dropped last job still schedules.
// Scheduling: one profit comparator walks the job store once per pick, n picks
//   for n jobs; after each pick the slot probe steps down from the deadline
//   one slot per cycle.
// Emission: the slot table is walked one slot per cycle up to the largest
//   deadline; each scheduled job gives one o_strobe pulse.
//   An empty schedule gives one pulse with o_has_job low.
// The last pulse carries o_final_result, the profit total and the job count;
//   busy falls in that same cycle and all batch state is cleared.
// Results are shown for exactly one cycle; the receiver cannot stall.
// Reset (synchronous, active low) empties the store and idles the block.
// ----------------------------------------------------------------------------
module deadline_job_scheduler #(
    parameter int JOB_CAPACITY = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [djs_pkg::IDENT_W-1:0]   i_job_ident,
    input  logic [djs_pkg::DL_W-1:0]      i_deadline,
    input  logic [djs_pkg::PROFIT_W-1:0]  i_profit,
    input  logic                          i_last_job,
    output logic                          o_strobe,
    output logic                          o_has_job,
    output logic [djs_pkg::IDENT_W-1:0]   o_sched_ident,
    output logic [djs_pkg::SLOT_W-1:0]    o_slot_index,
    output logic [djs_pkg::TOTAL_W-1:0]   o_total_profit,
    output logic [djs_pkg::COUNT_W-1:0]   o_job_count,
    output logic                          o_final_result
);
    import djs_pkg::*;

    localparam int IW = $clog2(JOB_CAPACITY);
    localparam int CW = $clog2(JOB_CAPACITY + 1);
    localparam logic [CW-1:0]   CAP_C  = CW'(JOB_CAPACITY);
    localparam logic [DL_W-1:0] CAP_DL = DL_W'(JOB_CAPACITY);

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_loaded, n_loaded;
    logic [CW-1:0]           r_largest, n_largest;
    logic [CW-1:0]           r_idx, n_idx;
    logic                    r_rd_vld, n_rd_vld;
    logic [IW-1:0]           r_rd_idx, n_rd_idx;
    logic [JOB_CAPACITY-1:0] r_done, n_done;
    logic                    r_best_vld, n_best_vld;
    logic [IW-1:0]           r_best_idx, n_best_idx;
    logic [PROFIT_W-1:0]     r_best_profit, n_best_profit;
    logic [IDENT_W-1:0]      r_best_ident, n_best_ident;
    logic [CW-1:0]           r_best_dl, n_best_dl;
    logic [CW-1:0]           r_pass, n_pass;
    logic [CW-1:0]           r_slot, n_slot;
    logic [TOTAL_W-1:0]      r_total, n_total;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [CW-1:0]           r_ei, n_ei;
    logic                    r_e_vld, n_e_vld;
    logic [CW-1:0]           r_e_slot, n_e_slot;
    logic [CW-1:0]           r_k, n_k;

    logic                    r_strobe, n_strobe;
    logic                    r_has, n_has;
    logic [IDENT_W-1:0]      r_o_ident, n_o_ident;
    logic [SLOT_W-1:0]       r_o_slot, n_o_slot;
    logic [TOTAL_W-1:0]      r_o_total, n_o_total;
    logic [COUNT_W-1:0]      r_o_cnt, n_o_cnt;
    logic                    r_fin, n_fin;

    logic                    accept;
    logic                    store_wr;
    logic [DL_W-1:0]         dl_sat;
    t_job_rec                wr_rec;
    t_job_rec                rd_rec;
    logic                    scan_issue;
    logic [CW-1:0]           slot_m1;
    logic [TOTAL_W:0]        total_sum;
    t_slot_ctl               slot_ctl;
    logic                    chk_taken;
    logic                    rd_taken;
    logic [IDENT_W-1:0]      rd_ident;
    logic                    emit_issue;

    assign busy     = (r_state != S_LOAD);
    assign accept   = start && !busy;
    assign store_wr = accept && (r_loaded != CAP_C);
    assign dl_sat   = (i_deadline > CAP_DL) ? CAP_DL : i_deadline;
    assign wr_rec   = '{ident: i_job_ident, deadline: dl_sat, profit: i_profit};

    assign scan_issue = (r_idx != r_loaded);
    assign emit_issue = (r_ei != r_largest);
    assign slot_m1    = r_slot - CW'(1);
    assign total_sum  = {1'b0, r_total} + (TOTAL_W + 1)'(r_best_profit);

    djs_job_store #(.JOB_CAPACITY(JOB_CAPACITY)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_wr),
        .i_wr_addr (r_loaded[IW-1:0]),
        .i_wr_rec  (wr_rec),
        .i_rd_addr (r_idx[IW-1:0]),
        .o_rd_rec  (rd_rec)
    );

    djs_slot_table #(.JOB_CAPACITY(JOB_CAPACITY)) u_slots (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (slot_ctl),
        .i_wr_addr   (slot_m1[IW-1:0]),
        .i_wr_ident  (r_best_ident),
        .o_chk_taken (chk_taken),
        .i_rd_addr   (r_ei[IW-1:0]),
        .o_rd_taken  (rd_taken),
        .o_rd_ident  (rd_ident)
    );

    always_comb begin
        n_state       = r_state;
        n_loaded      = r_loaded;
        n_largest     = r_largest;
        n_idx         = r_idx;
        n_rd_vld      = 1'b0;
        n_rd_idx      = r_rd_idx;
        n_done        = r_done;
        n_best_vld    = r_best_vld;
        n_best_idx    = r_best_idx;
        n_best_profit = r_best_profit;
        n_best_ident  = r_best_ident;
        n_best_dl     = r_best_dl;
        n_pass        = r_pass;
        n_slot        = r_slot;
        n_total       = r_total;
        n_cnt         = r_cnt;
        n_ei          = r_ei;
        n_e_vld       = 1'b0;
        n_e_slot      = r_e_slot;
        n_k           = r_k;
        n_strobe      = 1'b0;
        n_has         = 1'b0;
        n_o_ident     = '0;
        n_o_slot      = '0;
        n_o_total     = '0;
        n_o_cnt       = '0;
        n_fin         = 1'b0;
        slot_ctl      = '{set: 1'b0, clear: 1'b0};

        case (r_state)
            S_LOAD: begin
                if (store_wr) begin
                    n_loaded = r_loaded + CW'(1);
                    if (dl_sat[CW-1:0] > r_largest) begin
                        n_largest = dl_sat[CW-1:0];
                    end
                end
                if (accept && i_last_job) begin
                    n_state    = S_SCAN;
                    n_idx      = '0;
                    n_pass     = '0;
                    n_best_vld = 1'b0;
                    n_total    = '0;
                    n_cnt      = '0;
                end
            end
            S_SCAN: begin
                if (scan_issue) begin
                    n_idx    = r_idx + CW'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[IW-1:0];
                end
                if (r_rd_vld && !r_done[r_rd_idx]
                        && (!r_best_vld || rd_rec.profit > r_best_profit)) begin
                    n_best_vld    = 1'b1;
                    n_best_idx    = r_rd_idx;
                    n_best_profit = rd_rec.profit;
                    n_best_ident  = rd_rec.ident;
                    n_best_dl     = rd_rec.deadline[CW-1:0];
                end
                if (!scan_issue && !r_rd_vld) begin
                    n_done[r_best_idx] = 1'b1;
                    n_slot  = r_best_dl;
                    n_state = S_SLOT;
                end
            end
            S_SLOT: begin
                if (r_slot == '0 || !chk_taken) begin
                    if (r_slot != '0) begin
                        slot_ctl.set = 1'b1;
                        n_total = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
                        n_cnt   = r_cnt + CW'(1);
                    end
                    n_pass = r_pass + CW'(1);
                    if (n_pass == r_loaded) begin
                        n_state = S_EMIT;
                        n_ei    = '0;
                        n_k     = '0;
                    end else begin
                        n_state    = S_SCAN;
                        n_idx      = '0;
                        n_best_vld = 1'b0;
                    end
                end else begin
                    n_slot = slot_m1;
                end
            end
            S_EMIT: begin
                if (emit_issue) begin
                    n_ei     = r_ei + CW'(1);
                    n_e_vld  = 1'b1;
                    n_e_slot = r_ei;
                end
                if (r_cnt == '0) begin
                    n_strobe = 1'b1;
                    n_fin    = 1'b1;
                end else if (r_e_vld && rd_taken) begin
                    n_strobe  = 1'b1;
                    n_has     = 1'b1;
                    n_o_ident = rd_ident;
                    n_o_slot  = SLOT_W'(r_e_slot);
                    n_k       = r_k + CW'(1);
                    if (n_k == r_cnt) begin
                        n_fin     = 1'b1;
                        n_o_total = r_total;
                        n_o_cnt   = COUNT_W'(r_cnt);
                    end
                end
                if (n_fin) begin
                    n_state        = S_LOAD;
                    slot_ctl.clear = 1'b1;
                    n_done         = '0;
                    n_loaded       = '0;
                    n_largest      = '0;
                    n_total        = '0;
                    n_cnt          = '0;
                    n_e_vld        = 1'b0;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_loaded   <= '0;
            r_largest  <= '0;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_done     <= '0;
            r_best_vld <= 1'b0;
            r_pass     <= '0;
            r_slot     <= '0;
            r_total    <= '0;
            r_cnt      <= '0;
            r_ei       <= '0;
            r_e_vld    <= 1'b0;
            r_k        <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_loaded   <= n_loaded;
            r_largest  <= n_largest;
            r_idx      <= n_idx;
            r_rd_vld   <= n_rd_vld;
            r_done     <= n_done;
            r_best_vld <= n_best_vld;
            r_pass     <= n_pass;
            r_slot     <= n_slot;
            r_total    <= n_total;
            r_cnt      <= n_cnt;
            r_ei       <= n_ei;
            r_e_vld    <= n_e_vld;
            r_k        <= n_k;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx      <= n_rd_idx;
        r_best_idx    <= n_best_idx;
        r_best_profit <= n_best_profit;
        r_best_ident  <= n_best_ident;
        r_best_dl     <= n_best_dl;
        r_e_slot      <= n_e_slot;
        r_has         <= n_has;
        r_o_ident     <= n_o_ident;
        r_o_slot      <= n_o_slot;
        r_o_total     <= n_o_total;
        r_o_cnt       <= n_o_cnt;
        r_fin         <= n_fin;
    end

    assign o_strobe       = r_strobe;
    assign o_has_job      = r_has;
    assign o_sched_ident  = r_o_ident;
    assign o_slot_index   = r_o_slot;
    assign o_total_profit = r_o_total;
    assign o_job_count    = r_o_cnt;
    assign o_final_result = r_fin;

endmodule

/* design/djs_checker.sv */
// ----------------------------------------------------------------------------
// djs_checker: port-level checks of the deadline job scheduler
// Batch framing of results against the command handshake.
// ----------------------------------------------------------------------------
module djs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          i_last_job,
    input logic                          o_strobe,
    input logic                          o_has_job,
    input logic [djs_pkg::TOTAL_W-1:0]   o_total_profit,
    input logic [djs_pkg::COUNT_W-1:0]   o_job_count,
    input logic                          o_final_result
);
    import djs_pkg::*;

    a_final_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_final_result |-> !busy)
        else $error("busy still high on final result");

    a_empty_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_has_job |-> o_final_result && o_job_count == '0
            && o_total_profit == '0)
        else $error("empty result is not a clean final result");

    a_totals_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_final_result |-> o_job_count == '0 && o_total_profit == '0)
        else $error("totals shown before final result");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_last_job |=> !busy && !o_strobe)
        else $error("plain load transfer did not keep block idle");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_last_job |=> busy)
        else $error("last job transfer did not start scheduling");

endmodule

bind deadline_job_scheduler djs_checker u_djs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_last_job     (i_last_job),
    .o_strobe       (o_strobe),
    .o_has_job      (o_has_job),
    .o_total_profit (o_total_profit),
    .o_job_count    (o_job_count),
    .o_final_result (o_final_result)
);

/* verif/tb_deadline_job_scheduler.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_deadline_job_scheduler: self-checking bench for the deadline job scheduler
// Loads job batches through the start/busy handshake, predicts the greedy
// schedule of each batch in a scoreboard and checks every strobed slot result
// field by field. Directed batches cover the edge cases; random batches of
// mixed size, full-store batches, max-profit batches and noise follow, with sender idling.
// ----------------------------------------------------------------------------
module tb_deadline_job_scheduler;

    import djs_pkg::*;

    localparam int JOB_CAPACITY = 32;
    localparam int ITEM_TARGET  = 320;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct {
        logic                has_job;
        logic [IDENT_W-1:0]  ident;
        logic [SLOT_W-1:0]   slot;
        logic [TOTAL_W-1:0]  total;
        logic [COUNT_W-1:0]  count;
        logic                fin;
    } t_sched_res;

    typedef enum int {
        BK_MIXED,
        BK_FULL_STORE,
        BK_MAX_PROFIT,
        BK_NOISE
    } t_batch_kind;

    class schedule_checker;
        t_job_rec    jobs[JOB_CAPACITY];
        int unsigned n_loaded;
        int unsigned max_deadline;
        t_sched_res  pending_slots[$];
        int unsigned n_errors;

        function new();
            n_loaded     = 0;
            max_deadline = 0;
            n_errors     = 0;
        endfunction

        function int unsigned pending();
            return pending_slots.size();
        endfunction

        task report_mismatch(string msg);
            if (n_errors < 100) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            n_errors++;
        endtask

        function void plan_schedule();
            int unsigned rank[$];
            logic        slot_used[JOB_CAPACITY];
            logic [IDENT_W-1:0] slot_owner[JOB_CAPACITY];
            int unsigned total;
            int unsigned n_sched;
            int unsigned n_emitted;
            int unsigned pos;
            int unsigned s;
            int unsigned j;
            t_sched_res  res;
            // keep load order among equal profits
            for (int i = 0; i < n_loaded; i++) begin
                pos = rank.size();
                while (pos > 0 && jobs[rank[pos-1]].profit < jobs[i].profit) pos--;
                rank.insert(pos, i);
            end
            foreach (slot_used[i]) begin
                slot_used[i]  = 1'b0;
                slot_owner[i] = '0;
            end
            total   = 0;
            n_sched = 0;
            foreach (rank[k]) begin
                j = rank[k];
                s = 32'(jobs[j].deadline);
                while (s > 0 && slot_used[s-1]) s--;
                if (s > 0) begin
                    slot_used[s-1]  = 1'b1;
                    slot_owner[s-1] = jobs[j].ident;
                    total = total + 32'(jobs[j].profit);
                    if (total > TOTAL_MAX) total = 32'(TOTAL_MAX);
                    n_sched++;
                end
            end
            if (n_sched == 0) begin
                res = '{1'b0, '0, '0, '0, '0, 1'b1};
                pending_slots.push_back(res);
            end else begin
                n_emitted = 0;
                for (int i = 0; i < max_deadline; i++) begin
                    if (slot_used[i]) begin
                        n_emitted++;
                        res.has_job = 1'b1;
                        res.ident   = slot_owner[i];
                        res.slot    = SLOT_W'(i);
                        res.fin     = (n_emitted == n_sched);
                        res.total   = res.fin ? TOTAL_W'(total) : '0;
                        res.count   = res.fin ? COUNT_W'(n_sched) : '0;
                        pending_slots.push_back(res);
                    end
                end
            end
        endfunction

        function void note_job(t_job_rec job, logic last);
            int unsigned dl;
            if (n_loaded < JOB_CAPACITY) begin
                dl = 32'(job.deadline);
                if (dl > JOB_CAPACITY) dl = JOB_CAPACITY;
                job.deadline     = DL_W'(dl);
                jobs[n_loaded]   = job;
                if (dl > max_deadline) max_deadline = dl;
                n_loaded++;
            end
            if (last) begin
                plan_schedule();
                n_loaded     = 0;
                max_deadline = 0;
            end
        endfunction

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
            end
        endtask

        task check_result(t_sched_res got);
            t_sched_res want;
            if (pending_slots.size() == 0) begin
                report_mismatch($sformatf("unexpected result ident %0h slot %0d",
                                          got.ident, got.slot));
                return;
            end
            want = pending_slots.pop_front();
            check_field("has_job",      32'(got.has_job), 32'(want.has_job));
            check_field("sched_ident",  32'(got.ident),   32'(want.ident));
            check_field("slot_index",   32'(got.slot),    32'(want.slot));
            check_field("total_profit", 32'(got.total),   32'(want.total));
            check_field("job_count",    32'(got.count),   32'(want.count));
            check_field("final_result", 32'(got.fin),     32'(want.fin));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [IDENT_W-1:0]    i_job_ident;
    logic [DL_W-1:0]       i_deadline;
    logic [PROFIT_W-1:0]   i_profit;
    logic                  i_last_job;
    logic                  o_strobe;
    logic                  o_has_job;
    logic [IDENT_W-1:0]    o_sched_ident;
    logic [SLOT_W-1:0]     o_slot_index;
    logic [TOTAL_W-1:0]    o_total_profit;
    logic [COUNT_W-1:0]    o_job_count;
    logic                  o_final_result;

    schedule_checker sb = new();
    int unsigned     items_sent = 0;
    int unsigned     cycle_count = 0;
    t_sched_res      seen;

    deadline_job_scheduler #(
        .JOB_CAPACITY(JOB_CAPACITY)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_job_ident    (i_job_ident),
        .i_deadline     (i_deadline),
        .i_profit       (i_profit),
        .i_last_job     (i_last_job),
        .o_strobe       (o_strobe),
        .o_has_job      (o_has_job),
        .o_sched_ident  (o_sched_ident),
        .o_slot_index   (o_slot_index),
        .o_total_profit (o_total_profit),
        .o_job_count    (o_job_count),
        .o_final_result (o_final_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            seen.has_job = o_has_job;
            seen.ident   = o_sched_ident;
            seen.slot    = o_slot_index;
            seen.total   = o_total_profit;
            seen.count   = o_job_count;
            seen.fin     = o_final_result;
            sb.check_result(seen);
        end
    end

    task automatic pause_sender();
        if (!(items_sent >= 120 && items_sent < 200) && $urandom_range(0, 99) < 15) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic send_job(logic [IDENT_W-1:0] ident, logic [DL_W-1:0] dl,
                            logic [PROFIT_W-1:0] profit, logic last);
        t_job_rec job;
        pause_sender();
        start       <= 1'b1;
        i_job_ident <= ident;
        i_deadline  <= dl;
        i_profit    <= profit;
        i_last_job  <= last;
        do @(posedge i_clk); while (busy !== 1'b0);
        job.ident    = ident;
        job.deadline = dl;
        job.profit   = profit;
        sb.note_job(job, last);
        items_sent++;
    endtask

    function automatic logic [DL_W-1:0] rand_deadline();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return DL_W'($urandom_range(0, 8));
        if (r < 85) return DL_W'($urandom_range(0, 40));
        return DL_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [PROFIT_W-1:0] rand_profit();
        if ($urandom_range(0, 99) < 40) return PROFIT_W'($urandom_range(0, 15));
        return PROFIT_W'($urandom_range(0, 65535));
    endfunction

    task automatic run_batch(t_batch_kind kind);
        int unsigned        n_jobs;
        logic [DL_W-1:0]    dl;
        logic [PROFIT_W-1:0] profit;
        case (kind)
            BK_FULL_STORE: n_jobs = $urandom_range(JOB_CAPACITY + 1, JOB_CAPACITY + 4);
            BK_MAX_PROFIT: n_jobs = JOB_CAPACITY;
            BK_NOISE:      n_jobs = $urandom_range(1, 4);
            default:       n_jobs = $urandom_range(1, 8);
        endcase
        for (int unsigned k = 0; k < n_jobs; k++) begin
            case (kind)
                BK_MAX_PROFIT: begin
                    dl     = DL_W'($urandom_range(JOB_CAPACITY, 255));
                    profit = '1;
                end
                BK_NOISE: begin
                    dl     = ($urandom_range(0, 3) == 0) ? DL_W'(1) : '0;
                    profit = rand_profit();
                end
                default: begin
                    dl     = rand_deadline();
                    profit = rand_profit();
                end
            endcase
            send_job(IDENT_W'($urandom_range(0, 255)), dl, profit, k == n_jobs - 1);
        end
    endtask

    initial begin
        int unsigned r;
        int unsigned batch_no;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_job_ident <= '0;
        i_deadline  <= '0;
        i_profit    <= '0;
        i_last_job  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty schedule, then a lone job
        send_job(8'h5A, 8'd0, 16'hFFFF, 1'b1);
        send_job(8'hFF, 8'd1, 16'hFFFF, 1'b1);
        // saturating deadlines, zero profit, unschedulable top profit
        send_job(8'h00, 8'd255, 16'h0000, 1'b0);
        send_job(8'h41, 8'd33,  16'd100,  1'b0);
        send_job(8'h42, 8'd32,  16'd100,  1'b0);
        send_job(8'h43, 8'd2,   16'd100,  1'b0);
        send_job(8'h44, 8'd1,   16'hFFFF, 1'b0);
        send_job(8'h45, 8'd0,   16'hFFFF, 1'b1);
        // equal profits contending for one slot
        send_job(8'h10, 8'd1, 16'd500, 1'b0);
        send_job(8'h11, 8'd1, 16'd500, 1'b0);
        send_job(8'h12, 8'd1, 16'd500, 1'b1);
        // nothing schedulable
        send_job(8'h20, 8'd0, 16'd1, 1'b0);
        send_job(8'h21, 8'd0, 16'd0, 1'b1);
        send_job(8'hAA, 8'd3, 16'h5555, 1'b0);
        send_job(8'h55, 8'd3, 16'hAAAA, 1'b0);
        send_job(8'h0F, 8'd3, 16'h8000, 1'b1);

        batch_no = 0;
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (batch_no == 0)  run_batch(BK_MAX_PROFIT);
            else if (r < 6)     run_batch(BK_FULL_STORE);
            else if (r < 12)    run_batch(BK_NOISE);
            else if (r < 14)    run_batch(BK_MAX_PROFIT);
            else                run_batch(BK_MIXED);
            batch_no++;
        end
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4 * JOB_CAPACITY) @(posedge i_clk);
        if (sb.n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
design/djs_pkg.sv
design/djs_job_store.sv
design/djs_slot_table.sv
design/deadline_job_scheduler.sv
design/djs_checker.sv
verif/tb_deadline_job_scheduler.sv
